/* rtl/core/tmtw_pkg.sv */
// Shared types and constants for the text-mode terminal writer.
`default_nettype none

package tmtw_pkg;

	// Operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Control characters and fill values
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] COLOR_RESET  = 8'h0F;

	// Command beat
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic        echo_valid;
		logic [7:0]  echo_byte;
	} res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/text_mode_terminal_writer_top.sv */
// Top level of the text-mode terminal writer: screen memory, cursor and sequencer.
`default_nettype none

// Text-mode terminal writer. A command is taken when start is high and busy is low;
// its result appears on result, with done high for exactly one cycle, and the receiver
// cannot stall it. Timing is set by the single-port-per-direction screen memory:
// a put that does not scroll and an unused operation code raise done in the next
// cycle, and a new command may be taken in that same cycle. A read passes through
// the memory read register and the ST_READ state before done is raised. A put that
// scrolls copies SCREEN_WIDTH * (SCREEN_HEIGHT - 1) cells, one per cycle, then blanks
// the bottom row one cell per cycle once the last copy beat has been written. A clear
// writes every cell once. Busy stays high for the whole walk.
// The color register may be written only while busy is low and no command is pending.
module text_mode_terminal_writer_top #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire tmtw_pkg::cmd_t  command,
	output logic                 done,
	output tmtw_pkg::res_t       result,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata
);
	import tmtw_pkg::*;

	localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
	localparam int COL_W     = $clog2(SCREEN_WIDTH);
	localparam int LIN_W     = ADDR_W + 8;
	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW1_BASE     = ADDR_W'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(SCREEN_WIDTH - 1);

	// Screen memory and its read register
	logic [15:0]        screen_mem [CELLS];
	logic [15:0]        rdata_q;

	state_t             state_q, state_d;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [7:0]         color_q;
	logic               done_q;
	res_t               res_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic               copy_v_s1;
	logic [ADDR_W-1:0]  dst_s1;
	logic               rd_in_range_q;

	logic               accept;
	logic [ROW_W-1:0]   put_row;
	logic [COL_W-1:0]   put_col;
	logic               put_write;
	logic               need_scroll;
	logic [ADDR_W-1:0]  cur_addr;
	logic [LIN_W-1:0]   rd_lin;
	logic               rd_in_range;
	logic               blank_adv;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [15:0]        wr_data;

	assign accept = start && (state_q == ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Linear addresses of the cursor and of the requested cell
	assign cur_addr = ADDR_W'(cur_row_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_col_q);
	assign rd_lin   = LIN_W'(command.read_row) * LIN_W'(SCREEN_WIDTH)
		+ LIN_W'(command.read_column);
	assign rd_in_range = (int'(command.read_row) < SCREEN_HEIGHT)
		&& (int'(command.read_column) < SCREEN_WIDTH);

	// Decode a put: new cursor, cell write and scroll request
	always_comb begin
		put_row     = cur_row_q;
		put_col     = cur_col_q;
		put_write   = 1'b0;
		need_scroll = 1'b0;
		priority case (command.char_code)
			CH_NEWLINE: begin
				put_col = '0;
				if (cur_row_q == LAST_ROW) begin
					need_scroll = 1'b1;
				end else begin
					put_row = cur_row_q + ROW_W'(1);
				end
			end
			CH_RETURN: begin
				put_col = '0;
			end
			CH_BACKSPACE: begin
				if (cur_col_q != '0) begin
					put_col = cur_col_q - COL_W'(1);
				end
			end
			default: begin
				put_write = 1'b1;
				if (cur_col_q == LAST_COL) begin
					put_col = '0;
					if (cur_row_q == LAST_ROW) begin
						need_scroll = 1'b1;
					end else begin
						put_row = cur_row_q + ROW_W'(1);
					end
				end else begin
					put_col = cur_col_q + COL_W'(1);
				end
			end
		endcase
		if (command.operation != OP_PUT) begin
			need_scroll = 1'b0;
			put_write   = 1'b0;
		end
	end

	// Advance the blank walk only once the last copy beat has been written
	assign blank_adv = (state_q == ST_BLANK) && !copy_v_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command.operation)
						OP_PUT:   state_d = need_scroll ? ST_COPY : ST_IDLE;
						OP_CLEAR: state_d = ST_BLANK;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_COPY: begin
				if (ptr_q == LAST_ADDR) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (blank_adv && ptr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control and busy
	always_comb begin
		busy    = (state_q != ST_IDLE);
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = {color_q, command.char_code};
		if (state_q == ST_COPY) begin
			rd_en = 1'b1;
		end else if (accept && command.operation == OP_READ) begin
			rd_en   = 1'b1;
			rd_addr = rd_in_range ? rd_lin[ADDR_W-1:0] : '0;
		end
		priority if (copy_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = dst_s1;
			wr_data = rdata_q;
		end else if (state_q == ST_BLANK) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = {color_q, CH_SPACE};
		end else if (accept && put_write) begin
			wr_en = 1'b1;
		end
	end

	// Screen memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			screen_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= screen_mem[rd_addr];
		end
	end

	// Control state: sequencer, cursor, color, walk pointer, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_row_q <= '0;
			cur_col_q <= '0;
			color_q   <= COLOR_RESET;
			done_q    <= 1'b0;
			ptr_q     <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= 1'b0;
			copy_v_s1 <= (state_q == ST_COPY);
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (command.operation)
							OP_PUT: begin
								cur_row_q <= put_row;
								cur_col_q <= put_col;
								ptr_q     <= ROW1_BASE;
								done_q    <= !need_scroll;
							end
							OP_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								ptr_q     <= '0;
							end
							OP_READ: ;
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_READ: done_q <= 1'b1;
				ST_COPY: begin
					ptr_q <= (ptr_q == LAST_ADDR) ? LAST_ROW_BASE : ptr_q + ADDR_W'(1);
				end
				ST_BLANK: begin
					if (blank_adv) begin
						ptr_q <= ptr_q + ADDR_W'(1);
						if (ptr_q == LAST_ADDR) begin
							done_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload: result beat, copy destination, read range flag
	always_ff @(posedge clk) begin
		dst_s1 <= ptr_q - ROW1_BASE;
		if (accept) begin
			rd_in_range_q       <= rd_in_range;
			res_q.cell_value    <= '0;
			res_q.echo_valid    <= (command.operation == OP_PUT);
			res_q.echo_byte     <= (command.operation == OP_PUT) ? command.char_code : '0;
			unique case (command.operation)
				OP_PUT: begin
					res_q.cursor_row    <= 5'(need_scroll ? LAST_ROW : put_row);
					res_q.cursor_column <= 7'(put_col);
				end
				OP_CLEAR: begin
					res_q.cursor_row    <= '0;
					res_q.cursor_column <= '0;
				end
				default: begin
					res_q.cursor_row    <= 5'(cur_row_q);
					res_q.cursor_column <= 7'(cur_col_q);
				end
			endcase
		end else if (state_q == ST_READ) begin
			res_q.cell_value <= rd_in_range_q ? rdata_q : '0;
		end
	end

endmodule

`default_nettype wire
